// ===== rtl/core/gcode_position_tracker_unit_macros.svh =====
// assertion macros for the g-code position tracker
`ifndef GCODE_POSITION_TRACKER_UNIT_MACROS_SVH
`define GCODE_POSITION_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define GPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gpt_pkg.sv =====
// shared types, constants and helpers for the g-code position tracker
`default_nettype none

package gpt_pkg;

  localparam int NUM_AXES    = 3;
  localparam int VAL_W       = 32;
  localparam int OUT_W       = 32;
  localparam int SPT_W       = 20;
  localparam int CODE_W      = 10;
  localparam int MAG_W       = 36;
  localparam int QUO_W       = 30;
  localparam int QUEUE_DEPTH = 4;

  // reciprocal of five, exact for every 32-bit dividend
  localparam logic [VAL_W-1:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int               RECIP5_SHIFT = 34;

  localparam logic [CODE_W-1:0] G_RAPID  = 10'd0;
  localparam logic [CODE_W-1:0] G_LINEAR = 10'd1;
  localparam logic [CODE_W-1:0] G_INCH   = 10'd20;
  localparam logic [CODE_W-1:0] G_MM     = 10'd21;
  localparam logic [CODE_W-1:0] G_HOME   = 10'd28;
  localparam logic [CODE_W-1:0] G_ABS    = 10'd90;
  localparam logic [CODE_W-1:0] G_REL    = 10'd91;
  localparam logic [CODE_W-1:0] M_HOTEND = 10'd104;
  localparam logic [CODE_W-1:0] M_FAN    = 10'd106;
  localparam logic [CODE_W-1:0] M_BED    = 10'd140;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MOVE,
    OP_HOME,
    OP_HOTEND,
    OP_BED,
    OP_FAN
  } op_kind_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } axis_dist_t;

  typedef struct packed {
    op_kind_t                    kind;
    logic                        rel;
    logic [NUM_AXES-1:0]         present;
    logic [SPT_W-1:0]            s_value;
    axis_dist_t [NUM_AXES-1:0]   travel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // truncated 127 * r / 5 for a remainder r below five
  function automatic logic [6:0] rem_part(input logic [2:0] r);
    logic [6:0] v;
    case (r)
      3'd1:    v = 7'd25;
      3'd2:    v = 7'd50;
      3'd3:    v = 7'd76;
      3'd4:    v = 7'd101;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gpt_front.sv =====
// front end: accepts commands, tracks modes, scales axis words to micrometres
`default_nettype none

module gpt_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_g_present,
  input  logic [gpt_pkg::CODE_W-1:0]        in_g_number,
  input  logic                              in_m_present,
  input  logic [gpt_pkg::CODE_W-1:0]        in_m_number,
  input  logic                              in_x_present,
  input  logic signed [gpt_pkg::VAL_W-1:0]  in_x_value,
  input  logic                              in_y_present,
  input  logic signed [gpt_pkg::VAL_W-1:0]  in_y_value,
  input  logic                              in_z_present,
  input  logic signed [gpt_pkg::VAL_W-1:0]  in_z_value,
  input  logic                              in_e_present,
  input  logic [gpt_pkg::SPT_W-1:0]         in_s_value,
  input  gpt_pkg::q_status_t                q_status,
  output logic                              push,
  output gpt_pkg::cmd_t                     push_cmd
);

  typedef struct packed {
    gpt_pkg::op_kind_t                                    kind;
    logic                                                 rel;
    logic                                                 inch;
    logic [gpt_pkg::NUM_AXES-1:0]                         present;
    logic [gpt_pkg::SPT_W-1:0]                            s_value;
    logic [gpt_pkg::NUM_AXES-1:0]                         neg;
    logic [gpt_pkg::NUM_AXES-1:0][gpt_pkg::VAL_W-1:0]     mag;
  } stage_t;

  logic   adv;
  logic   accept;
  logic   inch_r, inch_nxt;
  logic   rel_r, rel_nxt;
  logic   f1_v_r, f2_v_r;
  stage_t stage_c, f1_r, f2_r;
  logic signed [gpt_pkg::VAL_W-1:0]                   vals [gpt_pkg::NUM_AXES];
  logic [2*gpt_pkg::VAL_W-1:0]                        prod_c [gpt_pkg::NUM_AXES];
  logic [gpt_pkg::NUM_AXES-1:0][gpt_pkg::QUO_W-1:0]   quo_c, f2_quo_r;
  logic [2:0]                                         rem_c [gpt_pkg::NUM_AXES];
  logic [gpt_pkg::MAG_W-1:0]                          scaled_c [gpt_pkg::NUM_AXES];

  assign adv      = ~f2_v_r | ~q_status.full;
  assign in_stall = ~adv;
  assign accept   = in_valid & adv;

  assign vals[0] = in_x_value;
  assign vals[1] = in_y_value;
  assign vals[2] = in_z_value;

  // decode g and m words into the command kind and modes; the e word is unused
  always_comb begin
    stage_c         = '0;
    stage_c.kind    = gpt_pkg::OP_NONE;
    stage_c.rel     = rel_r;
    stage_c.inch    = inch_r;
    stage_c.present = {in_z_present, in_y_present, in_x_present};
    stage_c.s_value = in_s_value;
    inch_nxt        = inch_r;
    rel_nxt         = rel_r;
    for (int i = 0; i < gpt_pkg::NUM_AXES; i++) begin
      stage_c.neg[i] = vals[i][gpt_pkg::VAL_W-1];
      stage_c.mag[i] = stage_c.neg[i] ? gpt_pkg::VAL_W'(-vals[i])
                                      : gpt_pkg::VAL_W'(vals[i]);
    end
    if (in_g_present) begin
      unique case (in_g_number) inside
        gpt_pkg::G_RAPID, gpt_pkg::G_LINEAR: stage_c.kind = gpt_pkg::OP_MOVE;
        gpt_pkg::G_HOME:                     stage_c.kind = gpt_pkg::OP_HOME;
        gpt_pkg::G_INCH:                     inch_nxt = 1'b1;
        gpt_pkg::G_MM:                       inch_nxt = 1'b0;
        gpt_pkg::G_ABS:                      rel_nxt = 1'b0;
        gpt_pkg::G_REL:                      rel_nxt = 1'b1;
        default: ;
      endcase
    end else if (in_m_present) begin
      unique case (in_m_number)
        gpt_pkg::M_HOTEND: stage_c.kind = gpt_pkg::OP_HOTEND;
        gpt_pkg::M_FAN:    stage_c.kind = gpt_pkg::OP_FAN;
        gpt_pkg::M_BED:    stage_c.kind = gpt_pkg::OP_BED;
        default: ;
      endcase
    end
  end

  // quotient by five of the magnitude
  always_comb begin
    for (int i = 0; i < gpt_pkg::NUM_AXES; i++) begin
      prod_c[i] = (2*gpt_pkg::VAL_W)'(f1_r.mag[i]) * (2*gpt_pkg::VAL_W)'(gpt_pkg::RECIP5);
      quo_c[i]  = prod_c[i][2*gpt_pkg::VAL_W-1:gpt_pkg::RECIP5_SHIFT];
    end
  end

  // 25.4 * m = 127 * q + 127 * r / 5 with m = 5q + r
  always_comb begin
    push_cmd         = '0;
    push_cmd.kind    = f2_r.kind;
    push_cmd.rel     = f2_r.rel;
    push_cmd.present = f2_r.present;
    push_cmd.s_value = f2_r.s_value;
    for (int i = 0; i < gpt_pkg::NUM_AXES; i++) begin
      rem_c[i]    = f2_r.mag[i][2:0] - 3'(f2_quo_r[i][2:0] * 3'd5);
      scaled_c[i] = (gpt_pkg::MAG_W'(f2_quo_r[i]) << 7) - gpt_pkg::MAG_W'(f2_quo_r[i])
                    + gpt_pkg::MAG_W'(gpt_pkg::rem_part(rem_c[i]));
      push_cmd.travel[i].neg = f2_r.neg[i];
      push_cmd.travel[i].mag = f2_r.inch ? scaled_c[i] : gpt_pkg::MAG_W'(f2_r.mag[i]);
    end
  end

  assign push = f2_v_r & ~q_status.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      inch_r <= 1'b0;
      rel_r  <= 1'b0;
    end else begin
      if (adv) begin
        f1_v_r <= in_valid;
        f2_v_r <= f1_v_r;
      end
      if (accept) begin
        inch_r <= inch_nxt;
        rel_r  <= rel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r     <= stage_c;
      f2_r     <= f1_r;
      f2_quo_r <= quo_c;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpt_queue.sv =====
// command queue between front end and execution
`default_nettype none

module gpt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gpt_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output gpt_pkg::cmd_t      pop_cmd,
  output gpt_pkg::q_status_t status
);

  localparam int DEPTH = gpt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  gpt_pkg::cmd_t    entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == (PTR_W+1)'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign pop_cmd      = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpt_back.sv =====
// execution: machine state, saturating moves, marks and the result register
`default_nettype none

module gpt_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gpt_pkg::q_status_t                q_status,
  input  gpt_pkg::cmd_t                     pop_cmd,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_x_pos,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_y_pos,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_z_pos,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_x_low_mark,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_x_high_mark,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_y_low_mark,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_y_high_mark,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_z_low_mark,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_z_high_mark,
  output logic [gpt_pkg::SPT_W-1:0]         out_hotend_temp,
  output logic [gpt_pkg::SPT_W-1:0]         out_bed_temp,
  output logic [gpt_pkg::SPT_W-1:0]         out_fan_level
);

  localparam int SUM_W = (COORD_WIDTH > gpt_pkg::MAG_W + 1) ? COORD_WIDTH + 1
                                                            : gpt_pkg::MAG_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  logic                            exec;
  logic                            out_valid_r;
  logic signed [COORD_WIDTH-1:0]   pos_r   [gpt_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0]   low_r   [gpt_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0]   high_r  [gpt_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0]   pos_nxt [gpt_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0]   low_nxt [gpt_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0]   high_nxt[gpt_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0]   moved_c [gpt_pkg::NUM_AXES];
  logic signed [SUM_W-1:0]         base_c  [gpt_pkg::NUM_AXES];
  logic signed [SUM_W-1:0]         mag_c   [gpt_pkg::NUM_AXES];
  logic signed [SUM_W-1:0]         sum_c   [gpt_pkg::NUM_AXES];
  logic [gpt_pkg::SPT_W-1:0]       hot_r, bed_r, fan_r;
  logic [gpt_pkg::SPT_W-1:0]       hot_nxt, bed_nxt, fan_nxt;

  assign exec = ~q_status.empty & (~out_valid_r | ~out_stall);
  assign pop  = exec;

  always_comb begin
    for (int i = 0; i < gpt_pkg::NUM_AXES; i++) begin
      base_c[i] = pop_cmd.rel ? SUM_W'(pos_r[i]) : '0;
      mag_c[i]  = SUM_W'(pop_cmd.travel[i].mag);
      sum_c[i]  = pop_cmd.travel[i].neg ? base_c[i] - mag_c[i] : base_c[i] + mag_c[i];
      if (sum_c[i] > SAT_HI) begin
        moved_c[i] = SAT_HI[COORD_WIDTH-1:0];
      end else if (sum_c[i] < SAT_LO) begin
        moved_c[i] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        moved_c[i] = sum_c[i][COORD_WIDTH-1:0];
      end
      pos_nxt[i]  = pos_r[i];
      low_nxt[i]  = low_r[i];
      high_nxt[i] = high_r[i];
      case (pop_cmd.kind)
        gpt_pkg::OP_MOVE: begin
          if (pop_cmd.present[i]) pos_nxt[i] = moved_c[i];
          if (pos_nxt[i] < low_r[i])  low_nxt[i]  = pos_nxt[i];
          if (pos_nxt[i] > high_r[i]) high_nxt[i] = pos_nxt[i];
        end
        gpt_pkg::OP_HOME: begin
          if (pop_cmd.present[i]) pos_nxt[i] = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    hot_nxt = hot_r;
    bed_nxt = bed_r;
    fan_nxt = fan_r;
    case (pop_cmd.kind)
      gpt_pkg::OP_HOTEND: hot_nxt = pop_cmd.s_value;
      gpt_pkg::OP_BED:    bed_nxt = pop_cmd.s_value;
      gpt_pkg::OP_FAN:    fan_nxt = pop_cmd.s_value;
      default: ;
    endcase
  end

  // state changes only when a result is loaded, so state is the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < gpt_pkg::NUM_AXES; i++) begin
        pos_r[i]  <= '0;
        low_r[i]  <= '0;
        high_r[i] <= '0;
      end
      hot_r <= '0;
      bed_r <= '0;
      fan_r <= '0;
    end else begin
      if (exec) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < gpt_pkg::NUM_AXES; i++) begin
          pos_r[i]  <= pos_nxt[i];
          low_r[i]  <= low_nxt[i];
          high_r[i] <= high_nxt[i];
        end
        hot_r <= hot_nxt;
        bed_r <= bed_nxt;
        fan_r <= fan_nxt;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_pos       = gpt_pkg::OUT_W'(pos_r[0]);
  assign out_y_pos       = gpt_pkg::OUT_W'(pos_r[1]);
  assign out_z_pos       = gpt_pkg::OUT_W'(pos_r[2]);
  assign out_x_low_mark  = gpt_pkg::OUT_W'(low_r[0]);
  assign out_x_high_mark = gpt_pkg::OUT_W'(high_r[0]);
  assign out_y_low_mark  = gpt_pkg::OUT_W'(low_r[1]);
  assign out_y_high_mark = gpt_pkg::OUT_W'(high_r[1]);
  assign out_z_low_mark  = gpt_pkg::OUT_W'(low_r[2]);
  assign out_z_high_mark = gpt_pkg::OUT_W'(high_r[2]);
  assign out_hotend_temp = hot_r;
  assign out_bed_temp    = bed_r;
  assign out_fan_level   = fan_r;

endmodule

`default_nettype wire

// ===== rtl/core/gcode_position_tracker_unit.sv =====
// top level of the g-code position tracker
// path: stages f1 and f2, then the queue, then the back end result registers
// throughput: one command per cycle while in_stall is low; the position update
//   loop stays in the back end, and a four-entry queue absorbs output stalls
// reset: synchronous, active low; clears positions, marks, setpoints and modes
`default_nettype none

module gcode_position_tracker_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_g_present,
  input  logic [gpt_pkg::CODE_W-1:0]        in_g_number,
  input  logic                              in_m_present,
  input  logic [gpt_pkg::CODE_W-1:0]        in_m_number,
  input  logic                              in_x_present,
  input  logic signed [gpt_pkg::VAL_W-1:0]  in_x_value,
  input  logic                              in_y_present,
  input  logic signed [gpt_pkg::VAL_W-1:0]  in_y_value,
  input  logic                              in_z_present,
  input  logic signed [gpt_pkg::VAL_W-1:0]  in_z_value,
  input  logic                              in_e_present,
  input  logic [gpt_pkg::SPT_W-1:0]         in_s_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_x_pos,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_y_pos,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_z_pos,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_x_low_mark,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_x_high_mark,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_y_low_mark,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_y_high_mark,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_z_low_mark,
  output logic signed [gpt_pkg::OUT_W-1:0]  out_z_high_mark,
  output logic [gpt_pkg::SPT_W-1:0]         out_hotend_temp,
  output logic [gpt_pkg::SPT_W-1:0]         out_bed_temp,
  output logic [gpt_pkg::SPT_W-1:0]         out_fan_level
);

  gpt_pkg::q_status_t q_status;
  gpt_pkg::cmd_t      push_cmd;
  gpt_pkg::cmd_t      pop_cmd;
  logic               push;
  logic               pop;

  gpt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_g_present (in_g_present),
    .in_g_number  (in_g_number),
    .in_m_present (in_m_present),
    .in_m_number  (in_m_number),
    .in_x_present (in_x_present),
    .in_x_value   (in_x_value),
    .in_y_present (in_y_present),
    .in_y_value   (in_y_value),
    .in_z_present (in_z_present),
    .in_z_value   (in_z_value),
    .in_e_present (in_e_present),
    .in_s_value   (in_s_value),
    .q_status     (q_status),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  gpt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  gpt_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .pop_cmd         (pop_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_pos       (out_x_pos),
    .out_y_pos       (out_y_pos),
    .out_z_pos       (out_z_pos),
    .out_x_low_mark  (out_x_low_mark),
    .out_x_high_mark (out_x_high_mark),
    .out_y_low_mark  (out_y_low_mark),
    .out_y_high_mark (out_y_high_mark),
    .out_z_low_mark  (out_z_low_mark),
    .out_z_high_mark (out_z_high_mark),
    .out_hotend_temp (out_hotend_temp),
    .out_bed_temp    (out_bed_temp),
    .out_fan_level   (out_fan_level)
  );

endmodule

`default_nettype wire

// ===== rtl/core/gpt_checker.sv =====
// port-level assertions for the g-code position tracker, bound to the top level
`default_nettype none
`include "gcode_position_tracker_unit_macros.svh"

module gpt_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [gpt_pkg::OUT_W-1:0]  out_x_pos,
  input logic signed [gpt_pkg::OUT_W-1:0]  out_y_pos,
  input logic signed [gpt_pkg::OUT_W-1:0]  out_z_pos,
  input logic signed [gpt_pkg::OUT_W-1:0]  out_x_low_mark,
  input logic signed [gpt_pkg::OUT_W-1:0]  out_x_high_mark,
  input logic signed [gpt_pkg::OUT_W-1:0]  out_y_low_mark,
  input logic signed [gpt_pkg::OUT_W-1:0]  out_y_high_mark,
  input logic signed [gpt_pkg::OUT_W-1:0]  out_z_low_mark,
  input logic signed [gpt_pkg::OUT_W-1:0]  out_z_high_mark,
  input logic [gpt_pkg::SPT_W-1:0]         out_hotend_temp,
  input logic [gpt_pkg::SPT_W-1:0]         out_bed_temp,
  input logic [gpt_pkg::SPT_W-1:0]         out_fan_level
);

  logic       in_acc, out_acc;
  logic [3:0] pending_r, pending_nxt;
  logic [9*gpt_pkg::OUT_W+3*gpt_pkg::SPT_W-1:0] payload;

  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;
  assign payload = {out_x_pos, out_y_pos, out_z_pos,
                    out_x_low_mark, out_x_high_mark,
                    out_y_low_mark, out_y_high_mark,
                    out_z_low_mark, out_z_high_mark,
                    out_hotend_temp, out_bed_temp, out_fan_level};

  // transactions in flight between the two channels
  always_comb begin
    pending_nxt = pending_r + 4'(in_acc) - 4'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `GPT_ASSERT_NXT(a_out_valid_held, out_valid && out_stall, out_valid, "result dropped while stalled")
  `GPT_ASSERT_NXT(a_out_payload_held, out_valid && out_stall, $stable(payload), "stalled result changed")
  `GPT_ASSERT_IMP(a_no_unasked_result, out_valid, pending_r != 4'd0, "result without a command")
  `GPT_ASSERT_IMP(a_marks_bracket, out_valid && (COORD_WIDTH <= 32), out_x_low_mark <= out_x_pos && out_x_pos <= out_x_high_mark && out_y_low_mark <= out_y_pos && out_y_pos <= out_y_high_mark && out_z_low_mark <= out_z_pos && out_z_pos <= out_z_high_mark, "position outside marks")

endmodule

bind gcode_position_tracker_unit gpt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_gpt_checker (.*);

`default_nettype wire
